// File: hdl/psg_shadow_register_flusher_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shadow register flusher
// Shared property forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef PSG_SHADOW_REGISTER_FLUSHER_TOP_ASSERT_SVH
`define PSG_SHADOW_REGISTER_FLUSHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psf: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psf: next-cycle property failed");

`endif

// File: hdl/psf_pkg.sv
// ----------------------------------------------------------------------------
// Shadow register flusher package
// Types, constants and the register layout decode shared by all modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

   localparam int NUM_REGS = 11;
   localparam int IDX_W    = 4;
   localparam int VAL_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [BYTE_W-1:0] LATCH_BASE  = 8'h80;
   localparam logic [BYTE_W-1:0] VOLUME_FLAG = 8'h10;
   localparam logic [BYTE_W-1:0] NOISE_CTRL  = 8'hE0;
   localparam logic [BYTE_W-1:0] NOISE_VOL   = 8'hF0;
   localparam logic [BYTE_W-1:0] MASK_LOW3   = 8'h07;
   localparam logic [BYTE_W-1:0] MASK_LOW4   = 8'h0F;
   localparam logic [BYTE_W-1:0] MASK_LOW6   = 8'h3F;

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_LOW,
      KIND_HIGH,
      KIND_VOL,
      KIND_NCTL,
      KIND_NVOL
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DATA
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] voice;
   } reg_info_type;

   // Register layout: three registers per tone voice, then the noise pair.
   function automatic reg_info_type reg_info(input logic [IDX_W-1:0] idx);
      reg_info_type info;
      info = '{kind: KIND_NVOL, voice: 2'd0};
      case (idx)
         4'd0:    info = '{kind: KIND_LOW,  voice: 2'd0};
         4'd1:    info = '{kind: KIND_HIGH, voice: 2'd0};
         4'd2:    info = '{kind: KIND_VOL,  voice: 2'd0};
         4'd3:    info = '{kind: KIND_LOW,  voice: 2'd1};
         4'd4:    info = '{kind: KIND_HIGH, voice: 2'd1};
         4'd5:    info = '{kind: KIND_VOL,  voice: 2'd1};
         4'd6:    info = '{kind: KIND_LOW,  voice: 2'd2};
         4'd7:    info = '{kind: KIND_HIGH, voice: 2'd2};
         4'd8:    info = '{kind: KIND_VOL,  voice: 2'd2};
         4'd9:    info = '{kind: KIND_NCTL, voice: 2'd0};
         default: info = '{kind: KIND_NVOL, voice: 2'd0};
      endcase
      return info;
   endfunction

endpackage

`default_nettype wire

// File: hdl/psf_front.sv
// ----------------------------------------------------------------------------
// Shadow register flusher front end
// Accepts items, drops writes to nonexistent registers, stages commands.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_front
   import psf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_func,
   input  wire logic [IDX_W-1:0] req_reg_index,
   input  wire logic [VAL_W-1:0] req_reg_value,
   input  wire q_stat_type       q_stat,
   output logic                  push,
   output cmd_type               push_cmd
);

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_cmd_ff, stage_cmd_in;
   logic    accept;
   logic    keep;

   always_comb begin
      busy     = stage_valid_ff & q_stat.full;
      push     = stage_valid_ff & ~q_stat.full;
      push_cmd = stage_cmd_ff;
      accept   = start & ~busy;
      // A write to a register that does not exist changes nothing.
      keep     = accept & ((req_func == OP_FLUSH) ||
                           (req_reg_index < IDX_W'(NUM_REGS)));
      stage_valid_in = keep | (stage_valid_ff & q_stat.full);
      stage_cmd_in   = stage_cmd_ff;
      if (keep) begin
         stage_cmd_in.op    = op_type'(req_func);
         stage_cmd_in.index = req_reg_index;
         stage_cmd_in.value = req_reg_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

`default_nettype wire

// File: hdl/psf_queue.sv
// ----------------------------------------------------------------------------
// Shadow register flusher command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_queue
   import psf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output q_stat_type   q_stat
);

   cmd_type              slot_ff [Q_DEPTH];
   cmd_type              slot_in [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      q_stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
      q_stat.empty = (count_ff == '0);
      head_cmd     = slot_ff[rd_ptr_ff];
      do_push      = push & ~q_stat.full;
      do_pop       = pop & ~q_stat.empty;
      slot_in      = slot_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

// File: hdl/psf_back.sv
// ----------------------------------------------------------------------------
// Shadow register flusher back end
// Holds the shadow registers and dirty bits and emits flush byte streams.
// ----------------------------------------------------------------------------
`default_nettype none

`include "psg_shadow_register_flusher_top_assert.svh"

module psf_back
   import psf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire q_stat_type        q_stat,
   input  wire cmd_type           head_cmd,
   output logic                   pop,
   output logic                   rsp_strobe,
   output logic [BYTE_W-1:0]      rsp_chip_byte,
   output logic                   rsp_last_byte
);

   state_type           state_ff, state_in;
   logic [VAL_W-1:0]    shadow_ff [NUM_REGS];
   logic [VAL_W-1:0]    shadow_in [NUM_REGS];
   logic [NUM_REGS-1:0] dirty_ff, dirty_in;
   logic [NUM_REGS-1:0] pending_ff, pending_in;
   logic                strobe_ff, strobe_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;

   logic [NUM_REGS-1:0] lowest;
   logic [NUM_REGS-1:0] rest;
   logic [IDX_W-1:0]    cur_idx;
   logic [IDX_W-1:0]    rd_addr;
   logic [VAL_W-1:0]    rd_value;
   logic [BYTE_W-1:0]   val_byte;
   logic [BYTE_W-1:0]   voice_bits;
   reg_info_type        info;

   // Lowest pending register, and what remains once it is done.
   always_comb begin
      lowest  = pending_ff & (~pending_ff + 1'b1);
      rest    = pending_ff & ~lowest;
      cur_idx = '0;
      for (int i = NUM_REGS - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            cur_idx = IDX_W'(i);
         end
      end
      info = reg_info(cur_idx);
      // The latch of a period high register carries the low register's value.
      if (state_ff == ST_EMIT && info.kind == KIND_HIGH) begin
         rd_addr = cur_idx - 1'b1;
      end else begin
         rd_addr = cur_idx;
      end
      rd_value   = shadow_ff[rd_addr];
      val_byte   = {{(BYTE_W - VAL_W){1'b0}}, rd_value};
      voice_bits = {3'b000, info.voice, 3'b000} << 2;
   end

   always_comb begin
      state_in   = state_ff;
      shadow_in  = shadow_ff;
      dirty_in   = dirty_ff;
      pending_in = pending_ff;
      strobe_in  = 1'b0;
      byte_in    = byte_ff;
      last_in    = 1'b0;
      pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop = 1'b1;
               if (head_cmd.op == OP_FLUSH) begin
                  pending_in = dirty_ff;
                  dirty_in   = '0;
                  state_in   = ST_EMIT;
               end else begin
                  shadow_in[head_cmd.index] = head_cmd.value;
                  dirty_in[head_cmd.index]  = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (pending_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               strobe_in = 1'b1;
               case (info.kind)
                  KIND_LOW:  byte_in = LATCH_BASE | voice_bits | (val_byte & MASK_LOW4);
                  KIND_HIGH: byte_in = LATCH_BASE | voice_bits | (val_byte & MASK_LOW4);
                  KIND_VOL:  byte_in = LATCH_BASE | voice_bits | VOLUME_FLAG |
                                       (val_byte & MASK_LOW4);
                  KIND_NCTL: byte_in = NOISE_CTRL | (val_byte & MASK_LOW3);
                  default:   byte_in = NOISE_VOL | (val_byte & MASK_LOW4);
               endcase
               if (info.kind == KIND_HIGH) begin
                  state_in = ST_DATA;
               end else begin
                  pending_in = rest;
                  last_in    = (rest == '0);
               end
            end
         end
         ST_DATA: begin
            strobe_in  = 1'b1;
            byte_in    = val_byte & MASK_LOW6;
            pending_in = rest;
            last_in    = (rest == '0);
            state_in   = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dirty_ff   <= '0;
         pending_ff <= '0;
         strobe_ff  <= 1'b0;
         last_ff    <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            shadow_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         dirty_ff   <= dirty_in;
         pending_ff <= pending_in;
         strobe_ff  <= strobe_in;
         last_ff    <= last_in;
         shadow_ff  <= shadow_in;
      end
      byte_ff <= byte_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_chip_byte = byte_ff;
   assign rsp_last_byte = last_ff;

   `PSF_ASSERT_NEXT(a_quiet_after_last, clock, reset, strobe_ff && last_ff, !strobe_ff)
   `PSF_ASSERT_NOW(a_data_follows_latch, clock, reset, state_ff == ST_DATA, strobe_ff)
   `PSF_ASSERT_NOW(a_no_dirty_in_flush, clock, reset, state_ff != ST_IDLE, dirty_ff == '0)

endmodule

`default_nettype wire

// File: hdl/psg_shadow_register_flusher_top.sv
// ----------------------------------------------------------------------------
// Shadow register flusher, top level
// Shadow copy of a four-voice sound chip's registers with dirty tracking.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a rising clock edge with start high and busy
// low. A write item (req_func = 0) stores req_reg_value into shadow register
// req_reg_index and marks it dirty; indexes eleven and up are dropped. A
// flush item (req_func = 1) walks the dirty registers in ascending order,
// clears all dirty bits and sends the chip bytes on rsp_chip_byte, one per
// cycle, each marked by a single-cycle rsp_strobe. rsp_last_byte is high on
// the final byte of a flush. A flush with nothing dirty sends no bytes.
// Flow. The front end stages an item in a register and the back end pulls it
// from a two-entry queue; each chip byte leaves through an output register.
// The back end takes one item at a time and finishes a flush's stream, at most
// fourteen bytes long, before it pulls the next item. Items keep being taken
// until the queue and the staging register are both full; busy then holds the
// sender off.
// Reset clears every shadow register, every dirty bit and the queue. There
// is no output backpressure: bytes must be taken as they appear.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_shadow_register_flusher_top
   import psf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_func,
   input  wire logic [IDX_W-1:0]  req_reg_index,
   input  wire logic [VAL_W-1:0]  req_reg_value,
   output logic                   rsp_strobe,
   output logic [BYTE_W-1:0]      rsp_chip_byte,
   output logic                   rsp_last_byte
);

   q_stat_type q_stat;
   logic       push;
   cmd_type    push_cmd;
   logic       pop;
   cmd_type    head_cmd;

   // Front end: accepts items and filters out writes to missing registers.
   psf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .q_stat        (q_stat),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // Queue: lets the front end keep taking items while a flush is running.
   psf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   // Back end: applies writes and turns flushes into chip byte streams.
   psf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_chip_byte (rsp_chip_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

// File: verif/psg_shadow_register_flusher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shadow register flusher checker
// Watches the command and byte channels. It keeps its own copy of the shadow
// registers and dirty bits, predicts the chip bytes of every flush and
// compares each strobed byte with the oldest prediction.
// ----------------------------------------------------------------------------

module psg_shadow_register_flusher_checker
   import psf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic              req_func,
   input  logic [IDX_W-1:0]  req_reg_index,
   input  logic [VAL_W-1:0]  req_reg_value,
   input  logic              rsp_strobe,
   input  logic [BYTE_W-1:0] rsp_chip_byte,
   input  logic              rsp_last_byte,
   output int                mismatch_count,
   output int                bytes_pending
);

   localparam int NOISE_CTRL_REG = 9;
   localparam int NOISE_VOL_REG  = 10;
   localparam int REGS_PER_VOICE = 3;

   typedef struct packed {
      logic [BYTE_W-1:0] chip_byte;
      logic              last_byte;
   } chip_write_type;

   logic [VAL_W-1:0]    shadow_copy [NUM_REGS];
   logic [NUM_REGS-1:0] dirty_copy;
   chip_write_type      expected_writes [$];

   // Appends the bytes of one flush, in register order, and clears the dirty bits.
   task automatic queue_flush_bytes();
      int             emitted;
      int             voice;
      kind_type       kind;
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] value;
      chip_write_type tail;
      emitted = 0;
      for (int r = 0; r < NUM_REGS; r++) begin
         if (dirty_copy[r]) begin
            value = BYTE_W'(shadow_copy[r]);
            voice = r / REGS_PER_VOICE;
            base  = LATCH_BASE | BYTE_W'(voice << 5);
            if (r == NOISE_CTRL_REG) begin
               kind = KIND_NCTL;
            end else if (r == NOISE_VOL_REG) begin
               kind = KIND_NVOL;
            end else begin
               case (r % REGS_PER_VOICE)
                  0: kind = KIND_LOW;
                  1: kind = KIND_HIGH;
                  default: kind = KIND_VOL;
               endcase
            end
            case (kind)
               KIND_LOW: begin
                  expected_writes.push_back('{base | (value & MASK_LOW4), 1'b0});
                  emitted++;
               end
               KIND_HIGH: begin
                  // The latch always carries the stored low nibble, dirty or not.
                  expected_writes.push_back(
                     '{base | (BYTE_W'(shadow_copy[r-1]) & MASK_LOW4), 1'b0});
                  expected_writes.push_back('{value & MASK_LOW6, 1'b0});
                  emitted += 2;
               end
               KIND_VOL: begin
                  expected_writes.push_back(
                     '{base | VOLUME_FLAG | (value & MASK_LOW4), 1'b0});
                  emitted++;
               end
               KIND_NCTL: begin
                  expected_writes.push_back('{NOISE_CTRL | (value & MASK_LOW3), 1'b0});
                  emitted++;
               end
               default: begin
                  expected_writes.push_back('{NOISE_VOL | (value & MASK_LOW4), 1'b0});
                  emitted++;
               end
            endcase
         end
      end
      dirty_copy = '0;
      if (emitted > 0) begin
         tail = expected_writes.pop_back();
         tail.last_byte = 1'b1;
         expected_writes.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      chip_write_type want;
      if (reset) begin
         expected_writes.delete();
         foreach (shadow_copy[r]) shadow_copy[r] = '0;
         dirty_copy = '0;
      end else begin
         // Bytes on the port now belong to items taken at earlier edges.
         if (rsp_strobe) begin
            if (expected_writes.size() == 0) begin
               $error("rsp_chip_byte: no byte expected, got %02h", rsp_chip_byte);
               mismatch_count++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_chip_byte !== want.chip_byte) begin
                  $error("rsp_chip_byte: expected %02h, got %02h",
                         want.chip_byte, rsp_chip_byte);
                  mismatch_count++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("rsp_last_byte: expected %0b, got %0b",
                         want.last_byte, rsp_last_byte);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_func == OP_FLUSH) begin
               queue_flush_bytes();
            end else if (req_reg_index < NUM_REGS) begin
               shadow_copy[req_reg_index] = req_reg_value;
               dirty_copy[req_reg_index]  = 1'b1;
            end
         end
      end
      bytes_pending = expected_writes.size();
   end

endmodule

// File: verif/psg_shadow_register_flusher_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shadow register flusher testbench
// Drives write and flush items into the flusher in random bursts and lets the
// checker beside it predict and compare every chip byte. A short directed
// opening covers the corner cases; a long random run follows.
// ----------------------------------------------------------------------------

module psg_shadow_register_flusher_top_test;
   import psf_pkg::*;

   // Number of counted random items. Writes to indexes past the last register
   // are dropped by the block, so they are sent but not counted.
   localparam int RANDOM_ITEMS = 190;
   // Cycles to wait once nothing is expected: enough for the staging register
   // and the two-entry queue to drain.
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_INDEX     = (1 << IDX_W) - 1;
   localparam int MAX_VALUE     = (1 << VAL_W) - 1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_func = 1'b0;
   logic [IDX_W-1:0]  req_reg_index = '0;
   logic [VAL_W-1:0]  req_reg_value = '0;
   logic              rsp_strobe;
   logic [BYTE_W-1:0] rsp_chip_byte;
   logic              rsp_last_byte;
   int                mismatch_count;
   int                bytes_pending;

   // State of the sender's burst pattern: items left in the current burst.
   int burst_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   psg_shadow_register_flusher_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_chip_byte (rsp_chip_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   psg_shadow_register_flusher_checker byte_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_reg_index  (req_reg_index),
      .req_reg_value  (req_reg_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_chip_byte  (rsp_chip_byte),
      .rsp_last_byte  (rsp_last_byte),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   // Presents one item and holds it until the block takes it, that is until an
   // edge sees start high and busy low. When the current burst runs out the
   // sender drops start for a random gap; a gap of zero chains two bursts, so
   // there are long stretches where items follow back to back. Start is only
   // lowered when a gap really follows, so a back-to-back item never sees start
   // lowered and raised within one time step.
   task automatic send_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
      int gap;
      start         <= 1'b1;
      req_func      <= op;
      req_reg_index <= idx;
      req_reg_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // A flush ignores its index and value, so they are random to exercise every
   // bit of those ports on flushes too.
   task automatic send_flush();
      send_item(OP_FLUSH, IDX_W'($urandom_range(0, MAX_INDEX)),
                VAL_W'($urandom_range(0, MAX_VALUE)));
   endtask

   initial begin
      int items_sent;
      int pick;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A flush straight after reset has nothing dirty and must
      // send nothing, even with every index and value bit set.
      send_item(OP_FLUSH, '1, '1);
      // A dirty period high on its own: its latch carries the clean, still zero
      // period low nibble, followed by the full six-bit data byte.
      send_item(OP_WRITE, IDX_W'(1), '1);
      send_flush();
      // Every index, the dropped ones past the noise volume included, with the
      // value extremes alternating. The flush after it sends the longest
      // possible stream of bytes, with lows sent before their latches.
      for (int i = 0; i <= MAX_INDEX; i++) begin
         send_item(OP_WRITE, IDX_W'(i), (i % 2) ? '1 : '0);
      end
      send_flush();
      // Everything was just cleaned, so this flush must be silent again.
      send_flush();

      // Random part. Mostly single register writes and flushes, now and then a
      // full refresh of all registers with random values followed by a flush,
      // plus a sprinkle of writes to indexes that the block drops.
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            for (int r = 0; r < NUM_REGS; r++) begin
               send_item(OP_WRITE, IDX_W'(r), VAL_W'($urandom_range(0, MAX_VALUE)));
            end
            send_flush();
            items_sent += NUM_REGS + 1;
         end else if (pick < 30) begin
            send_flush();
            items_sent++;
         end else if (pick < 38) begin
            send_item(OP_WRITE, IDX_W'($urandom_range(NUM_REGS, MAX_INDEX)),
                      VAL_W'($urandom_range(0, MAX_VALUE)));
         end else begin
            send_item(OP_WRITE, IDX_W'($urandom_range(0, NUM_REGS - 1)),
                      VAL_W'($urandom_range(0, MAX_VALUE)));
            items_sent++;
         end
      end
      // A last flush so that whatever was written at the end is sent out too.
      send_flush();
      start <= 1'b0;

      // Drain: wait for every predicted byte, then give the block time to show
      // any byte that was never predicted.
      while (bytes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("psg_shadow_register_flusher_top_test: PASS");
      end else begin
         $display("psg_shadow_register_flusher_top_test: FAIL");
      end
      $finish;
   end

   // Watchdog. A correct run takes a few tens of microseconds even with every
   // flush at its longest and every gap at its widest; this is far beyond that.
   initial begin
      #2000000;
      $display("psg_shadow_register_flusher_top_test: FAIL");
      $finish;
   end

endmodule
